FILE: sv/minmax_peak_decimator_macros.svh
// Assertion macros used by the minmax peak decimator datapath.
`ifndef MINMAX_PEAK_DECIMATOR_MACROS_SVH
`define MINMAX_PEAK_DECIMATOR_MACROS_SVH

`ifndef SYNTHESIS
`define MMPD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("minmax peak decimator assertion failed");
`define MMPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("minmax peak decimator assertion failed");
`else
`define MMPD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define MMPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: sv/mmpd_pkg.sv
// Types and constants shared by the minmax peak decimator modules.
`default_nettype none
package mmpd_pkg;

    localparam int CFG_W  = 16;
    localparam int BKT_W  = 15;
    localparam int SUM_W  = 16;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam int SLOT_N = 3;
    localparam int SLOT_W = 2;

    localparam logic [CFG_W-1:0] RECORD_LENGTH_RESET  = 16'd1024;
    localparam logic [CFG_W-1:0] POINT_CAPACITY_RESET = 16'd512;

    localparam logic REG_RECORD_LENGTH  = 1'b0;
    localparam logic REG_POINT_CAPACITY = 1'b1;

    localparam logic KIND_POINT  = 1'b0;
    localparam logic KIND_BOUNDS = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_UPDATE,
        ST_PLAN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic capture;
        logic div_start;
        logic update;
        logic plan;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic index_zero;
        logic div_done;
        logic out_free;
        logic slots_done;
        logic slot_last;
    } t_status;

endpackage
`default_nettype wire

FILE: sv/mmpd_div.sv
// Restoring divider that yields one quotient bit per cycle.
`default_nettype none
module mmpd_div
    import mmpd_pkg::*;
#(
    parameter int DW = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DW-1:0]    i_dividend,
    input  wire logic [BKT_W-1:0] i_divisor,
    output logic                  o_done,
    output logic [DW-1:0]         o_quotient,
    output logic [BKT_W-1:0]      o_remainder
);

    localparam int CW = $clog2(DW + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [DW-1:0]    r_quo;
    logic [BKT_W-1:0] r_rem;
    logic [BKT_W-1:0] r_div;

    logic [BKT_W:0]   trial;
    logic [BKT_W:0]   diff;
    logic             ge;

    always_comb begin
        trial = {r_rem, r_quo[DW-1]};
        ge    = trial >= {1'b0, r_div};
        diff  = trial - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CW'(DW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DW-2:0], ge};
            r_rem <= ge ? diff[BKT_W-1:0] : trial[BKT_W-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule
`default_nettype wire

FILE: sv/mmpd_datapath.sv
// Datapath: configuration registers, record extents, bucket extremes and output register.
`default_nettype none
`include "minmax_peak_decimator_macros.svh"
module mmpd_datapath
    import mmpd_pkg::*;
#(
    parameter int MAX_RECORD  = 32768,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ADDR_W-1:0]             paddr,
    input  wire logic [DATA_W-1:0]             pwdata,
    output logic      [DATA_W-1:0]             prdata,
    input  wire t_cmd                          i_cmd,
    output t_status                            o_status,
    input  wire logic signed [SAMPLE_BITS-1:0] i_y_sample,
    input  wire logic signed [SAMPLE_BITS-1:0] i_x_sample,
    input  wire logic                          i_x_present,
    input  wire logic                          i_out_stall,
    output logic                               o_out_valid,
    output logic                               o_item_kind,
    output logic signed [SAMPLE_BITS-1:0]      o_point_x,
    output logic signed [SAMPLE_BITS-1:0]      o_point_y,
    output logic signed [SAMPLE_BITS-1:0]      o_x_low,
    output logic signed [SAMPLE_BITS-1:0]      o_x_high,
    output logic signed [SAMPLE_BITS-1:0]      o_y_low,
    output logic signed [SAMPLE_BITS-1:0]      o_y_high,
    output logic                               o_run_last
);

    localparam int IW = $clog2(MAX_RECORD);
    localparam int LW = $clog2(MAX_RECORD + 1);
    localparam int XW = (IW > SAMPLE_BITS) ? IW : SAMPLE_BITS;
    localparam int SB = SAMPLE_BITS;

    // Configuration registers.
    logic [CFG_W-1:0] r_cfg_len;
    logic [CFG_W-1:0] r_cfg_cap;
    logic             cfg_we;

    assign cfg_we = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_len <= RECORD_LENGTH_RESET;
            r_cfg_cap <= POINT_CAPACITY_RESET;
        end else if (cfg_we) begin
            if (paddr[2] == REG_RECORD_LENGTH) begin
                r_cfg_len <= pwdata[CFG_W-1:0];
            end else begin
                r_cfg_cap <= pwdata[CFG_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_RECORD_LENGTH) ? DATA_W'(r_cfg_len) : DATA_W'(r_cfg_cap);

    // Effective record settings from the configuration registers.
    logic [LW-1:0]    len_eff;
    logic [CFG_W-1:0] cap_eff;
    logic [BKT_W-1:0] bkt_eff;
    logic             decim_eff;

    always_comb begin
        if (r_cfg_len == '0) begin
            len_eff = LW'(1);
        end else if (32'(r_cfg_len) > 32'(MAX_RECORD)) begin
            len_eff = LW'(MAX_RECORD);
        end else begin
            len_eff = LW'(r_cfg_len);
        end
        cap_eff   = (r_cfg_cap == '0) ? CFG_W'(1) : r_cfg_cap;
        bkt_eff   = (cap_eff[CFG_W-1:1] == '0) ? BKT_W'(1) : cap_eff[CFG_W-1:1];
        decim_eff = 32'(len_eff) > 32'(cap_eff);
    end

    // Record state.
    logic [IW-1:0]     r_index;
    logic [LW-1:0]     r_rec_len;
    logic [BKT_W-1:0]  r_buckets;
    logic              r_decimate;
    logic [LW-1:0]     r_step;
    logic [BKT_W-1:0]  r_frac;
    logic [LW:0]       r_bucket_end;
    logic [SUM_W-1:0]  r_brem;
    logic              r_bucket_open;
    logic              r_bucket_hit;
    logic              r_rec_end;

    logic signed [SB-1:0] r_x;
    logic signed [SB-1:0] r_y;

    logic signed [SB-1:0] r_bnd_xlo;
    logic signed [SB-1:0] r_bnd_xhi;
    logic signed [SB-1:0] r_bnd_ylo;
    logic signed [SB-1:0] r_bnd_yhi;

    logic signed [SB-1:0] r_min_y;
    logic signed [SB-1:0] r_min_x;
    logic [IW-1:0]        r_min_pos;
    logic signed [SB-1:0] r_max_y;
    logic signed [SB-1:0] r_max_x;
    logic [IW-1:0]        r_max_pos;

    // Divider for bucket size and remainder.
    logic             div_done;
    logic [LW-1:0]    div_quo;
    logic [BKT_W-1:0] div_rem;

    mmpd_div #(
        .DW (LW)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (len_eff),
        .i_divisor   (bkt_eff),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // Sample index as x.
    logic [XW-1:0]        idx_wide;
    logic signed [SB-1:0] idx_x;

    assign idx_wide = XW'(r_index);
    assign idx_x    = $signed(idx_wide[SB-1:0]);

    // Update step signals.
    logic [LW-1:0]    idx_p1;
    logic             first;
    logic             rec_end;
    logic             hit;
    logic             open_eff;
    logic [SUM_W-1:0] brem_sum;

    always_comb begin
        idx_p1   = LW'(r_index) + LW'(1);
        first    = (r_index == '0);
        rec_end  = idx_p1 >= r_rec_len;
        hit      = r_decimate && ({1'b0, idx_p1} == r_bucket_end);
        open_eff = r_bucket_open && !first;
        brem_sum = r_brem + SUM_W'(r_frac);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index       <= '0;
            r_rec_len     <= '0;
            r_buckets     <= '0;
            r_decimate    <= 1'b0;
            r_step        <= '0;
            r_frac        <= '0;
            r_bucket_end  <= '0;
            r_brem        <= '0;
            r_bucket_open <= 1'b0;
            r_bucket_hit  <= 1'b0;
            r_rec_end     <= 1'b0;
            r_bnd_xlo     <= '0;
            r_bnd_xhi     <= '0;
            r_bnd_ylo     <= '0;
            r_bnd_yhi     <= '0;
            r_min_y       <= '0;
            r_min_x       <= '0;
            r_min_pos     <= '0;
            r_max_y       <= '0;
            r_max_x       <= '0;
            r_max_pos     <= '0;
        end else begin
            if (i_cmd.capture && first) begin
                r_rec_len  <= len_eff;
                r_buckets  <= bkt_eff;
                r_decimate <= decim_eff;
            end
            if (div_done) begin
                r_step       <= div_quo;
                r_frac       <= div_rem;
                r_bucket_end <= {1'b0, div_quo};
                r_brem       <= SUM_W'(div_rem);
            end
            if (i_cmd.update) begin
                if (first) begin
                    r_bnd_xlo <= r_x;
                    r_bnd_xhi <= r_x;
                    r_bnd_ylo <= r_y;
                    r_bnd_yhi <= r_y;
                end else begin
                    if (r_x < r_bnd_xlo) r_bnd_xlo <= r_x;
                    if (r_x > r_bnd_xhi) r_bnd_xhi <= r_x;
                    if (r_y < r_bnd_ylo) r_bnd_ylo <= r_y;
                    if (r_y > r_bnd_yhi) r_bnd_yhi <= r_y;
                end
                if (r_decimate) begin
                    if (!open_eff) begin
                        r_min_y   <= r_y;
                        r_min_x   <= r_x;
                        r_min_pos <= r_index;
                        r_max_y   <= r_y;
                        r_max_x   <= r_x;
                        r_max_pos <= r_index;
                    end else begin
                        if (r_y < r_min_y) begin
                            r_min_y   <= r_y;
                            r_min_x   <= r_x;
                            r_min_pos <= r_index;
                        end
                        if (r_y > r_max_y) begin
                            r_max_y   <= r_y;
                            r_max_x   <= r_x;
                            r_max_pos <= r_index;
                        end
                    end
                end
                if (hit) begin
                    if (brem_sum >= SUM_W'(r_buckets)) begin
                        r_brem       <= brem_sum - SUM_W'(r_buckets);
                        r_bucket_end <= r_bucket_end + {1'b0, r_step} + (LW+1)'(1);
                    end else begin
                        r_brem       <= brem_sum;
                        r_bucket_end <= r_bucket_end + {1'b0, r_step};
                    end
                end
                r_bucket_open <= r_decimate && !hit;
                r_bucket_hit  <= hit;
                r_rec_end     <= rec_end;
                r_index       <= rec_end ? '0 : IW'(idx_p1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_y <= i_y_sample;
            r_x <= i_x_present ? i_x_sample : idx_x;
        end
    end

    // Result slots for the current sample.
    logic                 r_slot_kind [SLOT_N];
    logic signed [SB-1:0] r_slot_x    [SLOT_N];
    logic signed [SB-1:0] r_slot_y    [SLOT_N];
    logic [SLOT_W-1:0]    r_slot_cnt;
    logic [SLOT_W-1:0]    r_slot_ptr;

    logic                 n_slot_kind [SLOT_N];
    logic signed [SB-1:0] n_slot_x    [SLOT_N];
    logic signed [SB-1:0] n_slot_y    [SLOT_N];
    logic [SLOT_W-1:0]    n_slot_cnt;

    always_comb begin
        for (int i = 0; i < SLOT_N; i++) begin
            n_slot_kind[i] = KIND_POINT;
            n_slot_x[i]    = '0;
            n_slot_y[i]    = '0;
        end
        n_slot_cnt = '0;
        if (!r_decimate) begin
            n_slot_x[0] = r_x;
            n_slot_y[0] = r_y;
            n_slot_cnt  = SLOT_W'(1);
        end else if (r_bucket_hit) begin
            if (r_min_pos <= r_max_pos) begin
                n_slot_x[0] = r_min_x;
                n_slot_y[0] = r_min_y;
                n_slot_x[1] = r_max_x;
                n_slot_y[1] = r_max_y;
                n_slot_cnt  = (r_min_pos == r_max_pos) ? SLOT_W'(1) : SLOT_W'(2);
            end else begin
                n_slot_x[0] = r_max_x;
                n_slot_y[0] = r_max_y;
                n_slot_x[1] = r_min_x;
                n_slot_y[1] = r_min_y;
                n_slot_cnt  = SLOT_W'(2);
            end
        end
        if (r_rec_end) begin
            n_slot_kind[n_slot_cnt] = KIND_BOUNDS;
            n_slot_x[n_slot_cnt]    = '0;
            n_slot_y[n_slot_cnt]    = '0;
            n_slot_cnt              = n_slot_cnt + SLOT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.plan) begin
            for (int i = 0; i < SLOT_N; i++) begin
                r_slot_kind[i] <= n_slot_kind[i];
                r_slot_x[i]    <= n_slot_x[i];
                r_slot_y[i]    <= n_slot_y[i];
            end
        end
    end

    // Output register.
    logic                 r_out_valid;
    logic                 r_out_kind;
    logic signed [SB-1:0] r_out_px;
    logic signed [SB-1:0] r_out_py;
    logic signed [SB-1:0] r_out_xlo;
    logic signed [SB-1:0] r_out_xhi;
    logic signed [SB-1:0] r_out_ylo;
    logic signed [SB-1:0] r_out_yhi;
    logic                 r_out_last;
    logic                 slot_last;
    logic                 out_free;
    logic                 sel_kind;

    assign slot_last = (r_slot_ptr == r_slot_cnt - SLOT_W'(1));
    assign out_free  = !r_out_valid || !i_out_stall;
    assign sel_kind  = r_slot_kind[r_slot_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_cnt  <= '0;
            r_slot_ptr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.plan) begin
                r_slot_cnt <= n_slot_cnt;
                r_slot_ptr <= '0;
            end else if (i_cmd.emit) begin
                r_slot_ptr <= r_slot_ptr + SLOT_W'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_kind <= sel_kind;
            r_out_px   <= r_slot_x[r_slot_ptr];
            r_out_py   <= r_slot_y[r_slot_ptr];
            r_out_xlo  <= (sel_kind == KIND_BOUNDS) ? r_bnd_xlo : '0;
            r_out_xhi  <= (sel_kind == KIND_BOUNDS) ? r_bnd_xhi : '0;
            r_out_ylo  <= (sel_kind == KIND_BOUNDS) ? r_bnd_ylo : '0;
            r_out_yhi  <= (sel_kind == KIND_BOUNDS) ? r_bnd_yhi : '0;
            r_out_last <= slot_last;
        end
    end

    always_comb begin
        o_status.index_zero = first;
        o_status.div_done   = div_done;
        o_status.out_free   = out_free;
        o_status.slots_done = (r_slot_ptr == r_slot_cnt);
        o_status.slot_last  = slot_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_item_kind = r_out_kind;
    assign o_point_x   = r_out_px;
    assign o_point_y   = r_out_py;
    assign o_x_low     = r_out_xlo;
    assign o_x_high    = r_out_xhi;
    assign o_y_low     = r_out_ylo;
    assign o_y_high    = r_out_yhi;
    assign o_run_last  = r_out_last;

    `MMPD_ASSERT_IMPL(a_ptr_in_range, i_clk, i_rst_n, 1'b1, r_slot_ptr <= r_slot_cnt)
    `MMPD_ASSERT_IMPL(a_emit_has_slot, i_clk, i_rst_n, i_cmd.emit, r_slot_ptr < r_slot_cnt)
    `MMPD_ASSERT_IMPL(a_bounds_is_last, i_clk, i_rst_n, r_out_valid && (r_out_kind == KIND_BOUNDS), r_out_last)
    `MMPD_ASSERT_NEXT(a_emit_loads_out, i_clk, i_rst_n, i_cmd.emit, r_out_valid)

endmodule
`default_nettype wire

FILE: sv/mmpd_ctrl.sv
// Controller state machine sequencing capture, division, update, planning and emission.
`default_nettype none
module mmpd_ctrl
    import mmpd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    if (i_status.index_zero) begin
                        o_cmd.div_start = 1'b1;
                        n_state         = ST_DIV;
                    end else begin
                        n_state = ST_UPDATE;
                    end
                end
            end
            ST_DIV: begin
                if (i_status.div_done) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = ST_PLAN;
            end
            ST_PLAN: begin
                o_cmd.plan = 1'b1;
                n_state    = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_status.slots_done) begin
                    n_state = ST_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.slot_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: sv/minmax_peak_decimator.sv
// Top level of the minmax peak decimator.
// The block takes one sample request at a time. A sample that does not open a record passes
// through capture, update and planning before its first result is emitted, then emits each
// further result in turn, waiting while the output stall holds a result. The first sample of
// a record also runs the bucket-size divider, which produces one quotient bit per cycle,
// between capture and update. Each sample yields up to three results: the kept point, or a
// bucket's minimum and maximum points, and the bounds item after the last sample of a record.
// Settings are latched at the first sample of a record.
`default_nettype none
module minmax_peak_decimator
    import mmpd_pkg::*;
#(
    parameter int MAX_RECORD  = 32768,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ADDR_W-1:0]             paddr,
    input  wire logic [DATA_W-1:0]             pwdata,
    output logic      [DATA_W-1:0]             prdata,
    output logic                               pready,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0] i_y_sample,
    input  wire logic signed [SAMPLE_BITS-1:0] i_x_sample,
    input  wire logic                          i_x_present,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic                               o_item_kind,
    output logic signed [SAMPLE_BITS-1:0]      o_point_x,
    output logic signed [SAMPLE_BITS-1:0]      o_point_y,
    output logic signed [SAMPLE_BITS-1:0]      o_x_low,
    output logic signed [SAMPLE_BITS-1:0]      o_x_high,
    output logic signed [SAMPLE_BITS-1:0]      o_y_low,
    output logic signed [SAMPLE_BITS-1:0]      o_y_high,
    output logic                               o_run_last
);

    t_cmd    cmd;
    t_status status;

    assign pready = 1'b1;

    mmpd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    mmpd_datapath #(
        .MAX_RECORD  (MAX_RECORD),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_y_sample  (i_y_sample),
        .i_x_sample  (i_x_sample),
        .i_x_present (i_x_present),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_item_kind (o_item_kind),
        .o_point_x   (o_point_x),
        .o_point_y   (o_point_y),
        .o_x_low     (o_x_low),
        .o_x_high    (o_x_high),
        .o_y_low     (o_y_low),
        .o_y_high    (o_y_high),
        .o_run_last  (o_run_last)
    );

endmodule
`default_nettype wire
